// File: design/rsa_pkg.sv
// rsa_pkg: constants, parse phase type and pipeline payload structs for the
// range sensor average unit. No dependencies.
`default_nettype none

package rsa_pkg;

  localparam int RING_DEPTH = 16;
  localparam int LINE_LIMIT = 11;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int TOTAL_W    = 32 + SLOT_W;
  localparam int COUNT_W    = $clog2(LINE_LIMIT + 1);

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // pulse scaling: width * 1715 / 10000, the divide done as a reciprocal multiply
  localparam int               PROD_W      = 28;
  localparam int               RECIP_W     = 28;
  localparam int               FULL_W      = PROD_W + RECIP_W;
  localparam int               RECIP_SHIFT = 41;
  localparam logic [PROD_W-1:0]  PULSE_MUL   = 28'd1715;
  localparam logic [RECIP_W-1:0] PULSE_RECIP = 28'd219902326;

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_DIGITS,
    PH_DONE
  } rsa_phase_t;

  typedef struct packed {
    logic        store;
    logic        pulse;
    logic [31:0] value;
  } rsa_raw_t;

  typedef struct packed {
    logic        store;
    logic [31:0] sample;
  } rsa_sample_t;

endpackage

`default_nettype wire

// File: design/rsa_if.sv
// rsa_if: valid/ready channel interfaces for the input beat and the result beat.
// No dependencies.
`default_nettype none

interface rsa_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [16:0] pulse_us;

  modport source (output valid, output rx_byte, output pulse_us, input ready);
  modport sink (input valid, input rx_byte, input pulse_us, output ready);
endinterface

interface rsa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] distance;
  logic               sample_stored;

  modport source (output valid, output distance, output sample_stored, input ready);
  modport sink (input valid, input distance, input sample_stored, output ready);
endinterface

`default_nettype wire

// File: design/range_sensor_average_unit.sv
// range_sensor_average_unit: top level of the range sensor front end.
// Depends on rsa_pkg, rsa_if, rsa_parser, rsa_scaler and rsa_ring.
//
// Takes one input beat per cycle while the result side is not stalled and
// returns one result beat per input beat, in order. The pipeline has four
// stages: byte parse or pulse multiply by 1715, reciprocal multiply for the
// divide by 10000, ring memory read, and running total update into the result
// register. source_mode selects serial ASCII bytes (0) or echo pulse widths (1);
// the user must write it only while no beat is in flight, and the block does not
// enforce this. The 16-entry ring reads as zero after reset through per-entry
// valid flags, so there is no clearing pass and the first beat is taken at once.
`default_nettype none

module range_sensor_average_unit (
  input  wire logic clk,
  input  wire logic rst,
  rsa_in_if.sink    item,
  rsa_out_if.source result,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  import rsa_pkg::*;

  logic        source_mode;
  logic        raw_valid;
  logic        raw_ready;
  rsa_raw_t    raw;
  logic        samp_valid;
  logic        samp_ready;
  rsa_sample_t samp;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_mode <= 1'b0;
    end else if (cfg_we) begin
      source_mode <= cfg_wdata;
    end
  end

  rsa_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .source_mode (source_mode),
    .item        (item),
    .raw_valid   (raw_valid),
    .raw         (raw),
    .raw_ready   (raw_ready)
  );

  rsa_scaler u_scaler (
    .clk        (clk),
    .rst        (rst),
    .raw_valid  (raw_valid),
    .raw        (raw),
    .raw_ready  (raw_ready),
    .samp_valid (samp_valid),
    .samp       (samp),
    .samp_ready (samp_ready)
  );

  rsa_ring u_ring (
    .clk        (clk),
    .rst        (rst),
    .samp_valid (samp_valid),
    .samp       (samp),
    .samp_ready (samp_ready),
    .result     (result)
  );

endmodule

`default_nettype wire

// File: design/rsa_parser.sv
// rsa_parser: ascii decimal line parser and pulse pre-multiply, first pipeline stage.
// Depends on rsa_pkg and rsa_in_if.
`default_nettype none

module rsa_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       source_mode,
  rsa_in_if.sink          item,
  output logic            raw_valid,
  output rsa_pkg::rsa_raw_t raw,
  input  wire logic       raw_ready
);
  import rsa_pkg::*;

  rsa_phase_t         phase;
  rsa_phase_t         phase_next;
  logic [31:0]        value;
  logic [31:0]        value_next;
  logic               negative;
  logic               negative_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] count_inc;
  rsa_raw_t           raw_next;
  logic [PROD_W-1:0]  pulse_prod;
  logic [31:0]        digit_val;
  logic               accept;
  logic               is_cr;
  logic               is_digit;
  logic               is_blank;
  logic               is_sign;
  logic               line_full;

  assign item.ready = !raw_valid || raw_ready;
  assign accept     = item.valid && item.ready;

  assign is_cr     = item.rx_byte == CHAR_CR;
  assign is_digit  = item.rx_byte >= CHAR_ZERO && item.rx_byte <= CHAR_NINE;
  assign is_blank  = item.rx_byte == CHAR_SPACE ||
                     (item.rx_byte >= CHAR_TAB && item.rx_byte <= CHAR_FF);
  assign is_sign   = item.rx_byte == CHAR_PLUS || item.rx_byte == CHAR_MINUS;
  assign digit_val = {24'd0, item.rx_byte - CHAR_ZERO};
  assign count_inc = count + 1'b1;
  assign line_full = count_inc == COUNT_W'(LINE_LIMIT);

  assign pulse_prod = PROD_W'(item.pulse_us) * PULSE_MUL;

  always_comb begin
    phase_next = phase;
    if (!source_mode) begin
      if (is_cr || line_full) begin
        phase_next = PH_BLANK;
      end else begin
        unique case (phase)
          PH_BLANK: begin
            if (is_sign || is_digit) begin
              phase_next = PH_DIGITS;
            end else if (!is_blank) begin
              phase_next = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (!is_digit) begin
              phase_next = PH_DONE;
            end
          end
          PH_DONE: phase_next = PH_DONE;
          default: phase_next = PH_BLANK;
        endcase
      end
    end
  end

  always_comb begin
    value_next    = value;
    negative_next = negative;
    count_next    = count;
    raw_next.pulse = source_mode;
    raw_next.store = source_mode || is_cr;
    raw_next.value = source_mode ? {{(32 - PROD_W){1'b0}}, pulse_prod} :
                     (negative ? 32'd0 - value : value);
    if (!source_mode) begin
      if (is_cr || line_full) begin
        value_next    = '0;
        negative_next = 1'b0;
        count_next    = '0;
      end else begin
        count_next = count_inc;
        unique case (phase)
          PH_BLANK: begin
            if (is_sign) begin
              negative_next = item.rx_byte == CHAR_MINUS;
            end else if (is_digit) begin
              value_next = digit_val;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              value_next = (value << 3) + (value << 1) + digit_val;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BLANK;
      value     <= '0;
      negative  <= 1'b0;
      count     <= '0;
      raw_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase    <= phase_next;
        value    <= value_next;
        negative <= negative_next;
        count    <= count_next;
        raw_valid <= 1'b1;
      end else if (raw_ready) begin
        raw_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw <= raw_next;
    end
  end

endmodule

`default_nettype wire

// File: design/rsa_scaler.sv
// rsa_scaler: reciprocal multiply that finishes the pulse divide by 10000.
// Depends on rsa_pkg.
`default_nettype none

module rsa_scaler (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          raw_valid,
  input  rsa_pkg::rsa_raw_t  raw,
  output logic               raw_ready,
  output logic               samp_valid,
  output rsa_pkg::rsa_sample_t samp,
  input  wire logic          samp_ready
);
  import rsa_pkg::*;

  logic [FULL_W-1:0] full_prod;
  logic              load;

  assign raw_ready = !samp_valid || samp_ready;
  assign load      = raw_valid && raw_ready;
  assign full_prod = FULL_W'(raw.value[PROD_W-1:0]) * FULL_W'(PULSE_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      samp_valid <= 1'b0;
    end else begin
      if (load) begin
        samp_valid <= 1'b1;
      end else if (samp_ready) begin
        samp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      samp.store  <= raw.store;
      samp.sample <= raw.pulse ? 32'(full_prod >> RECIP_SHIFT) : raw.value;
    end
  end

endmodule

`default_nettype wire

// File: design/rsa_ring.sv
// rsa_ring: sample ring memory, running total and result register.
// Depends on rsa_pkg and rsa_out_if.
`default_nettype none

module rsa_ring (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            samp_valid,
  input  rsa_pkg::rsa_sample_t samp,
  output logic                 samp_ready,
  rsa_out_if.source            result
);
  import rsa_pkg::*;

  logic [31:0]         ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld;
  logic [31:0]         rd_data;
  logic                rd_vld;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   slot_inc;
  logic [SLOT_W-1:0]   rd_addr;
  logic                s3_valid;
  logic                s3_store;
  logic [31:0]         s3_sample;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  total_next;
  logic [TOTAL_W-1:0]  out_total;
  logic [TOTAL_W-1:0]  rounded;
  logic [31:0]         old_val;
  logic                s3_ready;
  logic                s3_fire;
  logic                s3_load;
  logic                wr_en;

  assign s3_ready   = !s3_valid || !result.valid || result.ready;
  assign s3_fire    = s3_valid && (!result.valid || result.ready);
  assign s3_load    = samp_valid && s3_ready;
  assign samp_ready = s3_ready;
  assign wr_en      = s3_fire && s3_store;

  assign slot_inc = (slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
  // the beat leaving stage three moves the slot on as the next one reads
  assign rd_addr  = wr_en ? slot_inc : slot;

  assign old_val    = rd_vld ? rd_data : '0;
  assign total_next = total - {{(TOTAL_W - 32){old_val[31]}}, old_val}
                            + {{(TOTAL_W - 32){s3_sample[31]}}, s3_sample};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[slot] <= s3_sample;
    end
    if (s3_load) begin
      rd_data <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld     <= '0;
      rd_vld       <= 1'b0;
      slot         <= '0;
      total        <= '0;
      s3_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (s3_load) begin
        rd_vld <= ring_vld[rd_addr];
      end
      if (wr_en) begin
        ring_vld[slot] <= 1'b1;
        slot           <= slot_inc;
        total          <= total_next;
      end
      if (s3_load) begin
        s3_valid <= 1'b1;
      end else if (s3_fire) begin
        s3_valid <= 1'b0;
      end
      if (s3_fire) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_store  <= samp.store;
      s3_sample <= samp.sample;
    end
    if (s3_fire) begin
      result.sample_stored <= s3_store;
      out_total            <= s3_store ? total_next : total;
    end
  end

  // divide by the depth, truncated toward zero
  assign rounded = out_total + (out_total[TOTAL_W-1] ? TOTAL_W'(RING_DEPTH - 1) : '0);
  assign result.distance = rounded[TOTAL_W-1:SLOT_W];

endmodule

`default_nettype wire

// File: design/rsa_checker.sv
// rsa_checker: port-level assertions for the range sensor average unit,
// bound to range_sensor_average_unit. No package dependency.
`default_nettype none

module rsa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [31:0] distance,
  input wire logic        sample_stored,
  input wire logic        cfg_we,
  input wire logic        cfg_wdata
);

  logic        mode;
  logic [31:0] last_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      last_dist <= '0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (result_valid && result_ready) begin
        last_dist <= distance;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(distance) && $stable(sample_stored))
    else $error("stalled result beat changed");

  a_no_store_keeps_avg: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !sample_stored |-> distance == last_dist)
    else $error("average moved without a stored sample");

  a_pulse_stores: assert property (@(posedge clk) disable iff (rst)
    result_valid && mode |-> sample_stored)
    else $error("pulse mode beat did not store a sample");

endmodule

bind range_sensor_average_unit rsa_checker u_rsa_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .distance      (result.distance),
  .sample_stored (result.sample_stored),
  .cfg_we        (cfg_we),
  .cfg_wdata     (cfg_wdata)
);

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for range_sensor_average_unit, serial ascii lines and echo widths
// feed a local distance predictor, results checked in order per beat.
// Depends on rsa_pkg, rsa_if and the range_sensor_average_unit rtl.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsa_pkg::*;

  localparam longint SCALE_NUM   = 1715;
  localparam longint SCALE_DEN   = 10000;
  localparam int     HOLD_CYCLES = 64;
  localparam int     PHASE_BEATS = 80;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               stored;
  } distance_beat_t;

  typedef struct packed {
    logic           mode;
    logic [7:0]     rx;
    logic [16:0]    pulse;
    logic           typed;
    distance_beat_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  rsa_in_if  in_ch ();
  rsa_out_if out_ch ();

  range_sensor_average_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (in_ch),
    .result    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // predictor state
  logic [31:0]    ring_mem [RING_DEPTH] = '{default: '0};
  int unsigned    wr_slot = 0;
  longint         ring_sum = 0;
  int unsigned    line_len = 0;
  logic [31:0]    acc_value = '0;
  logic           acc_neg = 1'b0;
  rsa_phase_t     acc_phase = PH_BLANK;
  logic           cur_mode = 1'b0;

  distance_beat_t distance_q [$];
  int             mismatches = 0;
  int             beats_sent = 0;
  logic           hold_req = 1'b0;
  logic           steady = 1'b0;

  function automatic void clear_line();
    line_len  = 0;
    acc_value = '0;
    acc_neg   = 1'b0;
    acc_phase = PH_BLANK;
  endfunction

  function automatic distance_beat_t predict_distance(input logic [7:0] b,
                                                      input logic [16:0] p);
    distance_beat_t r;
    logic [31:0]    smp;
    logic           digit;
    logic           blank;
    r.stored = 1'b0;
    smp      = '0;
    digit    = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    blank    = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_FF));
    if (cur_mode) begin
      smp      = 32'((longint'(p) * SCALE_NUM) / SCALE_DEN);
      r.stored = 1'b1;
    end else if (b == CHAR_CR) begin
      smp      = acc_neg ? 32'(-acc_value) : acc_value;
      r.stored = 1'b1;
      clear_line();
    end else begin
      case (acc_phase)
        PH_BLANK: begin
          if (!blank) begin
            if (b == CHAR_PLUS || b == CHAR_MINUS) begin
              acc_neg   = (b == CHAR_MINUS);
              acc_phase = PH_DIGITS;
            end else if (digit) begin
              acc_value = 32'(b - CHAR_ZERO);
              acc_phase = PH_DIGITS;
            end else begin
              acc_phase = PH_DONE;
            end
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            acc_value = acc_value * 32'd10 + 32'(b - CHAR_ZERO);
          end else begin
            acc_phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      line_len++;
      if (line_len >= LINE_LIMIT) clear_line();
    end
    if (r.stored) begin
      ring_sum = ring_sum - longint'($signed(ring_mem[wr_slot])) + longint'($signed(smp));
      ring_mem[wr_slot] = smp;
      wr_slot = (wr_slot + 1) % RING_DEPTH;
    end
    r.distance = 32'(ring_sum / RING_DEPTH);
    return r;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic [16:0] p,
                           input logic typed, input distance_beat_t given);
    distance_beat_t want;
    if (!steady && $urandom_range(0, 99) < 13) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.rx_byte  <= b;
    in_ch.pulse_us <= p;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    want = predict_distance(b, p);
    distance_q.push_back(typed ? given : want);
    beats_sent++;
  endtask

  task automatic set_mode(input logic m);
    in_ch.valid <= 1'b0;
    while (distance_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = m;
  endtask

  // mostly well-formed lines, some noise and some lines left without a cr
  task automatic send_line();
    int         pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 17'($urandom), 1'b0, '0);
    end else begin
      repeat ($urandom_range(0, 2)) begin
        c = CHAR_TAB + 8'($urandom_range(0, 4));
        if (c > CHAR_FF) c = CHAR_SPACE;
        send_beat(c, 17'($urandom), 1'b0, '0);
      end
      pick = $urandom_range(0, 3);
      if (pick == 0) send_beat(CHAR_PLUS, 17'($urandom), 1'b0, '0);
      if (pick == 1) send_beat(CHAR_MINUS, 17'($urandom), 1'b0, '0);
      repeat ($urandom_range(1, 10)) begin
        send_beat(CHAR_ZERO + 8'($urandom_range(0, 9)), 17'($urandom), 1'b0, '0);
      end
      if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 17'($urandom), 1'b0, '0);
      if ($urandom_range(0, 19) != 0) send_beat(CHAR_CR, 17'($urandom), 1'b0, '0);
    end
  endtask

  directed_row_t steps [26] = '{
    '{1'b0, 8'h00,               17'd0,      1'b1, '{32'sd0, 1'b0}},
    '{1'b0, CHAR_CR,             17'd0,      1'b1, '{32'sd0, 1'b1}},
    '{1'b0, CHAR_SPACE,          17'd0,      1'b0, '0},
    '{1'b0, CHAR_TAB,            17'd0,      1'b0, '0},
    '{1'b0, CHAR_MINUS,          17'd0,      1'b0, '0},
    '{1'b0, CHAR_ZERO + 8'd7,    17'd0,      1'b0, '0},
    '{1'b0, CHAR_PLUS,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_CR,             17'd0,      1'b0, '0},
    '{1'b0, CHAR_MINUS,          17'd0,      1'b0, '0},
    '{1'b0, CHAR_CR,             17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_NINE,           17'd0,      1'b0, '0},
    '{1'b0, CHAR_CR,             17'd0,      1'b0, '0},
    '{1'b1, 8'h00,               17'h1FFFF,  1'b0, '0},
    '{1'b1, 8'hFF,               17'd0,      1'b0, '0},
    '{1'b1, 8'h00,               17'd1,      1'b0, '0},
    '{1'b0, 8'hFF,               17'h1FFFF,  1'b0, '0}
  };

  initial begin
    int          pick;
    int          target;
    logic [16:0] width;
    in_ch.valid    <= 1'b0;
    in_ch.rx_byte  <= '0;
    in_ch.pulse_us <= '0;
    while (rst) @(posedge clk);

    set_mode(1'b0);
    foreach (steps[i]) begin
      if (steps[i].mode != cur_mode) set_mode(steps[i].mode);
      send_beat(steps[i].rx, steps[i].pulse, steps[i].typed, steps[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0]);
      if (ph == 2) hold_req <= 1'b1;
      steady <= (ph == 3);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        if (ph[0]) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) width = 17'h1FFFF;
          else if (pick < 20) width = '0;
          else if (pick < 50) width = 17'($urandom_range(0, 2000));
          else width = 17'($urandom);
          send_beat(8'($urandom), width, 1'b0, '0);
        end else begin
          send_line();
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (distance_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side back-pressure, with one long hold-off so the pipe fills
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left < HOLD_CYCLES) begin
        hold_left++;
        out_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 13) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    distance_beat_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (distance_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, got distance %0d stored %0b",
                 $time, out_ch.distance, out_ch.sample_stored);
        mismatches++;
      end else begin
        want = distance_q.pop_front();
        if (out_ch.distance !== want.distance) begin
          $display("%0t: distance expected %0d, got %0d",
                   $time, want.distance, out_ch.distance);
          mismatches++;
        end
        if (out_ch.sample_stored !== want.stored) begin
          $display("%0t: sample_stored expected %0b, got %0b",
                   $time, want.stored, out_ch.sample_stored);
          mismatches++;
        end
      end
    end
  end

endmodule

`default_nettype wire
